>>> rtl/core/dslp_pkg.sv
package dslp_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TIME   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_TIME = 8'd1;

    // Register reset values in milliseconds
    localparam logic [15:0] DEBOUNCE_TIME_RESET   = 16'd20;
    localparam logic [15:0] LONG_PRESS_TIME_RESET = 16'd1000;

    // Press classification phase
    typedef enum logic [1:0] {
        PHASE_IDLE      = 2'd0,
        PHASE_DOWN      = 2'd1,
        PHASE_LONG_SENT = 2'd2
    } phase_t;

    // Reported event code
    typedef enum logic [1:0] {
        EVENT_NONE  = 2'd0,
        EVENT_SHORT = 2'd1,
        EVENT_LONG  = 2'd2
    } event_t;

    // One poll request as held in the input register
    typedef struct packed {
        logic        raw_level;
        logic [31:0] time_now;
    } dslp_step_t;

    // Timing settings handed to the engine
    typedef struct packed {
        logic [15:0] debounce_time;
        logic [15:0] long_press_time;
    } dslp_cfg_t;

endpackage

>>> rtl/core/dslp_if.sv
interface dslp_sample_if;
    logic        valid;
    logic        ready;
    logic        raw_level;
    logic [31:0] time_now;

    modport source (output valid, output raw_level, output time_now, input ready);
    modport sink   (input valid, input raw_level, input time_now, output ready);
endinterface

interface dslp_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] press_event;

    modport source (output valid, output press_event, input ready);
    modport sink   (input valid, input press_event, output ready);
endinterface

interface dslp_cfg_if
    import dslp_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/debounced_short_long_press.sv
// Button debounce with short and long press detection.
//
// sample: one poll request per accepted item, carrying the raw button level
//   (1 = pressed) and a free-running millisecond timestamp that wraps at 2^32.
// result: exactly one request per poll, press_event 0 none, 1 short, 2 long.
// cfg: register writes, index 0 debounce_time, index 1 long_press_time, both
//   in milliseconds; other indexes are dropped. cfg.ready is always high and
//   writes are expected only while no poll is in flight.
//
// Path: input register, engine, then output register.
// Throughput: one poll per cycle unless a held result stalls the input; the
// state update is a single pass through two 32-bit elapsed-time subtractions
// and the phase logic.
// Reset: the button reads released with its last level change at time 0,
// the registers return to 20 ms and 1000 ms, and both stages empty.
// Stall: a result held by the receiver stays in the output register; the
// input register still takes one more poll, then sample.ready drops.
module debounced_short_long_press
    import dslp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    dslp_sample_if.sink          sample,
    dslp_result_if.source        result,
    dslp_cfg_if.sink             cfg
);

    logic        in_valid_reg, in_valid_next;
    dslp_step_t  in_data_reg, in_data_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_event_reg, out_event_next;
    dslp_cfg_t   cfg_reg, cfg_next;

    logic        advance;
    logic        take;
    event_t      step_event;

    // Move the held poll forward whenever the output slot is free
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign take         = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    assign result.valid       = out_valid_reg;
    assign result.press_event = out_event_reg;

    dslp_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .step        (in_data_reg),
        .cfg         (cfg_reg),
        .press_event (step_event)
    );

    // Load the input register and the result register
    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_data_next   = in_data_reg;
        out_valid_next = out_valid_reg;
        out_event_next = out_event_reg;
        if (take)
        begin
            in_valid_next          = 1'b1;
            in_data_next.raw_level = sample.raw_level;
            in_data_next.time_now  = sample.time_now;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_event_next = 2'(step_event);
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_DEBOUNCE_TIME:   cfg_next.debounce_time   = cfg.data;
                CFG_LONG_PRESS_TIME: cfg_next.long_press_time = cfg.data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            cfg_reg.debounce_time   <= DEBOUNCE_TIME_RESET;
            cfg_reg.long_press_time <= LONG_PRESS_TIME_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        in_data_reg   <= in_data_next;
        out_event_reg <= out_event_next;
    end

endmodule

>>> rtl/core/dslp_engine.sv
module dslp_engine
    import dslp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  dslp_step_t step,
    input  dslp_cfg_t  cfg,
    output event_t     press_event
);

    phase_t      phase_reg, phase_next;
    logic        prev_raw_reg, prev_raw_next;
    logic [31:0] change_time_reg, change_time_next;
    logic        stable_reg, stable_next;
    logic [31:0] start_time_reg, start_time_next;

    logic        changed;
    logic [31:0] since_change;
    logic [31:0] since_start;
    logic        settled;
    logic        press_edge;
    logic        release_edge;
    logic        held_long;

    // Debounce: a fresh level change restarts the timer at zero elapsed
    assign changed      = step.raw_level != prev_raw_reg;
    assign since_change = step.time_now - change_time_reg;
    assign since_start  = step.time_now - start_time_reg;
    assign settled      = changed ? (cfg.debounce_time == 16'd0)
                                  : (since_change >= {16'd0, cfg.debounce_time});
    assign press_edge   = settled && step.raw_level && !stable_reg;
    assign release_edge = settled && !step.raw_level && stable_reg;
    assign held_long    = since_start >= {16'd0, cfg.long_press_time};

    // Next state and event for the current request
    always_comb
    begin
        phase_next       = phase_reg;
        prev_raw_next    = prev_raw_reg;
        change_time_next = change_time_reg;
        stable_next      = stable_reg;
        start_time_next  = start_time_reg;
        press_event      = EVENT_NONE;
        if (step_en)
        begin
            prev_raw_next = step.raw_level;
            if (changed)
            begin
                change_time_next = step.time_now;
            end
            if (press_edge)
            begin
                stable_next = 1'b1;
            end
            else if (release_edge)
            begin
                stable_next = 1'b0;
            end
            unique case (phase_reg)
                PHASE_IDLE:
                begin
                    if (press_edge)
                    begin
                        phase_next      = PHASE_DOWN;
                        start_time_next = step.time_now;
                    end
                end
                PHASE_DOWN:
                begin
                    if (release_edge)
                    begin
                        phase_next  = PHASE_IDLE;
                        press_event = EVENT_SHORT;
                    end
                    else if (held_long)
                    begin
                        phase_next  = PHASE_LONG_SENT;
                        press_event = EVENT_LONG;
                    end
                end
                PHASE_LONG_SENT:
                begin
                    if (release_edge)
                    begin
                        phase_next = PHASE_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PHASE_IDLE;
                end
            endcase
        end
    end

    // Hold the debounce and phase state, released at time zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PHASE_IDLE;
            prev_raw_reg    <= 1'b0;
            change_time_reg <= 32'd0;
            stable_reg      <= 1'b0;
            start_time_reg  <= 32'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            prev_raw_reg    <= prev_raw_next;
            change_time_reg <= change_time_next;
            stable_reg      <= stable_next;
            start_time_reg  <= start_time_next;
        end
    end

endmodule

>>> rtl/core/dslp_checker.sv
module dslp_props (
    input logic       clk,
    input logic       rst_n,
    input logic       sample_valid,
    input logic       sample_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic [1:0] result_press_event,
    input logic       cfg_ready
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
    else $error("result request dropped while stalled");

    // A new result follows a poll accepted and passed through the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_valid && sample_ready, 2))
    else $error("result request without an accepted poll");

    // An empty output slot never holds back the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> sample_ready)
    else $error("poll refused while output slot is empty");

    // The unused event code never shows
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_press_event != 2'd3))
    else $error("invalid press event code");

    // Register writes are never refused
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
    else $error("configuration write refused");

endmodule

bind debounced_short_long_press dslp_props u_dslp_props (
    .clk                (clk),
    .rst_n              (rst_n),
    .sample_valid       (sample.valid),
    .sample_ready       (sample.ready),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .result_press_event (result.press_event),
    .cfg_ready          (cfg.ready)
);
